// File: rtl/ndi_pkg.sv
// ----------------------------------------------------------------------------
// ndi_pkg
// Shared types and codes for the Newton divided-difference interpolator.
// ----------------------------------------------------------------------------
package ndi_pkg;

  localparam int WORD_W = 32;
  localparam int STATUS_W = 3;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_EVAL  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                     done;
    logic                     sat;
    logic signed [WORD_W-1:0] quotient;
  } div_res_t;

endpackage

// File: rtl/newton_divided_difference_interp_unit.sv
// ----------------------------------------------------------------------------
// newton_divided_difference_interp_unit
// Newton-form interpolation in signed fixed point: clear, add point, evaluate.
//
//   channel  signals                                  direction
//   in       in_valid/in_ready, operation, x/y_value  to block
//   out      out_valid/out_ready, result_value,status from block
//
// One item at a time. Add: a read per stored point for the duplicate scan, then
// per row entry a read plus a divider pass. Evaluate: a read and a two-part
// multiply per stored point. Reset empties the table; no clearing pass. A result
// waiting in the output register keeps the next finished item pending, and no
// new item is taken until that pending result has moved out.
// ----------------------------------------------------------------------------
module newton_divided_difference_interp_unit
  import ndi_pkg::*;
#(
  parameter int MAX_POINTS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                operation,
  input  logic signed [WORD_W-1:0]  x_value,
  input  logic signed [WORD_W-1:0]  y_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [WORD_W-1:0]  result_value,
  output logic [STATUS_W-1:0]       status
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_DUP_RD   = 15'b000000000000010,
    S_DUP_CHK  = 15'b000000000000100,
    S_ROW_INIT = 15'b000000000001000,
    S_ROW_RD   = 15'b000000000010000,
    S_ROW_DIV  = 15'b000000000100000,
    S_ROW_WAIT = 15'b000000001000000,
    S_COEF_WR  = 15'b000000010000000,
    S_EV_RD0   = 15'b000000100000000,
    S_EV_INIT  = 15'b000001000000000,
    S_EV_RD    = 15'b000010000000000,
    S_EV_PREP  = 15'b000100000000000,
    S_EV_MLO   = 15'b001000000000000,
    S_EV_MHI   = 15'b010000000000000,
    S_EV_ACC   = 15'b100000000000000
  } state_t;

  state_t state;
  logic   done_pend;

  logic [CW-1:0]            count;
  logic [CW-1:0]            idx;
  logic signed [WORD_W-1:0] xr;
  logic signed [WORD_W-1:0] yr;
  logic signed [WORD_W-1:0] upper;
  logic signed [WORD_W-1:0] sum;
  logic signed [WORD_W-1:0] ci;
  logic                     sat;
  logic signed [WORD_W-1:0] res_hold;
  logic [STATUS_W-1:0]      st_hold;
  logic [31:0]              ma;
  logic [32:0]              mb;
  logic                     mneg;
  logic [47:0]              plo;
  logic [48:0]              phi;

  logic [CW-1:0] idx_m1;
  logic [AW-1:0] rd_addr;
  logic          a_we;
  logic [AW-1:0] a_waddr;
  logic [63:0]   a_wdata;
  logic [63:0]   a_rdata;
  logic          d_we;
  logic [AW-1:0] d_waddr;
  logic [31:0]   d_wdata;
  logic [31:0]   d_rdata;
  logic signed [WORD_W-1:0] ax;
  logic signed [WORD_W-1:0] ac;

  logic               div_start;
  logic signed [32:0] div_num;
  logic signed [32:0] div_den;
  div_res_t           div_res;

  logic signed [32:0] dval;
  logic [63:0]        prod;
  logic [63:0]        mshift;
  logic signed [65:0] pval;
  logic               p_ovf;
  logic signed [WORD_W-1:0] p_sat;

  assign idx_m1  = idx - CW'(1);
  assign rd_addr = (state == S_ROW_RD) ? idx_m1[AW-1:0] : idx[AW-1:0];
  assign ax      = signed'(a_rdata[63:32]);
  assign ac      = signed'(a_rdata[31:0]);

  ndi_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_abs_coef (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(rd_addr), .rdata(a_rdata)
  );

  ndi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_row (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(rd_addr), .rdata(d_rdata)
  );

  assign div_start = (state == S_ROW_DIV);
  assign div_num   = {upper[31], upper} - {d_rdata[31], d_rdata};
  assign div_den   = {xr[31], xr} - {ax[31], ax};

  ndi_divider #(.FRAC(FRACTION_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .numer(div_num), .denom(div_den), .res(div_res)
  );

  always_comb begin
    a_we    = 1'b0;
    a_waddr = count[AW-1:0];
    a_wdata = {xr, upper};
    d_we    = 1'b0;
    d_waddr = count[AW-1:0];
    d_wdata = yr;
    unique case (state)
      S_ROW_INIT: d_we = 1'b1;
      S_ROW_WAIT: begin
        d_we    = div_res.done;
        d_waddr = idx_m1[AW-1:0];
        d_wdata = div_res.quotient;
      end
      S_COEF_WR: a_we = 1'b1;
      default: ;
    endcase
  end

  assign dval   = {xr[31], xr} - {ax[31], ax};
  assign prod   = 64'(plo) + (64'(phi) << 16);
  assign mshift = prod >> FRACTION_BITS;
  assign pval   = (mneg ? -signed'(66'(mshift)) : signed'(66'(mshift))) + 66'(ci);
  assign p_ovf  = !((&pval[65:31]) || !(|pval[65:31]));
  assign p_sat  = p_ovf ? (pval[65] ? WORD_MIN : WORD_MAX) : pval[31:0];

  assign in_ready = (state == S_IDLE) && !done_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done_pend <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (done_pend && (!out_valid || out_ready)) begin
        out_valid    <= 1'b1;
        result_value <= res_hold;
        status       <= st_hold;
        done_pend    <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            xr       <= x_value;
            yr       <= y_value;
            upper    <= y_value;
            sat      <= 1'b0;
            idx      <= (operation == OP_EVAL) ? count - CW'(1) : '0;
            res_hold <= '0;
            st_hold  <= (operation == OP_ADD && count == CW'(MAX_POINTS)) ? ST_FULL :
                        (operation == OP_EVAL && count == '0) ? ST_EMPTY : ST_OK;
            case (operation)
              OP_CLEAR: begin
                count     <= '0;
                done_pend <= 1'b1;
              end
              OP_ADD: begin
                if (count == CW'(MAX_POINTS)) begin
                  done_pend <= 1'b1;
                end else if (count == '0) begin
                  state <= S_ROW_INIT;
                end else begin
                  state <= S_DUP_RD;
                end
              end
              OP_EVAL: begin
                if (count == '0) begin
                  done_pend <= 1'b1;
                end else begin
                  state <= S_EV_RD0;
                end
              end
              default: done_pend <= 1'b1;
            endcase
          end
        end
        S_DUP_RD: state <= S_DUP_CHK;
        S_DUP_CHK: begin
          if (ax == xr) begin
            st_hold   <= ST_DUPLICATE;
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end else if (idx + CW'(1) == count) begin
            state <= S_ROW_INIT;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_DUP_RD;
          end
        end
        S_ROW_INIT: begin
          idx   <= count;
          state <= (count == '0) ? S_COEF_WR : S_ROW_RD;
        end
        S_ROW_RD:  state <= S_ROW_DIV;
        S_ROW_DIV: state <= S_ROW_WAIT;
        S_ROW_WAIT: begin
          if (div_res.done) begin
            upper <= div_res.quotient;
            sat   <= sat | div_res.sat;
            idx   <= idx_m1;
            state <= (idx_m1 == '0) ? S_COEF_WR : S_ROW_RD;
          end
        end
        S_COEF_WR: begin
          count     <= count + CW'(1);
          st_hold   <= sat ? ST_SATURATED : ST_OK;
          done_pend <= 1'b1;
          state     <= S_IDLE;
        end
        S_EV_RD0: state <= S_EV_INIT;
        S_EV_INIT: begin
          sum <= ac;
          if (idx == '0) begin
            res_hold  <= ac;
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end else begin
            idx   <= idx_m1;
            state <= S_EV_RD;
          end
        end
        S_EV_RD: state <= S_EV_PREP;
        S_EV_PREP: begin
          ci    <= ac;
          ma    <= sum[31] ? 32'(-sum) : 32'(sum);
          mb    <= dval[32] ? 33'(-dval) : 33'(dval);
          mneg  <= sum[31] ^ dval[32];
          state <= S_EV_MLO;
        end
        S_EV_MLO: begin
          plo   <= ma * mb[15:0];
          state <= S_EV_MHI;
        end
        S_EV_MHI: begin
          phi   <= ma * mb[32:16];
          state <= S_EV_ACC;
        end
        S_EV_ACC: begin
          sum <= p_sat;
          if (idx == '0) begin
            res_hold  <= p_sat;
            st_hold   <= (sat | p_ovf) ? ST_SATURATED : ST_OK;
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end else begin
            sat   <= sat | p_ovf;
            idx   <= idx_m1;
            state <= S_EV_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ndi_ram.sv
// ----------------------------------------------------------------------------
// ndi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ndi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ndi_divider.sv
// ----------------------------------------------------------------------------
// ndi_divider
// Radix-2 restoring divider: (numer << FRAC) / denom, truncated toward zero,
// saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module ndi_divider
  import ndi_pkg::*;
#(
  parameter int FRAC = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] numer,
  input  logic signed [32:0] denom,
  output div_res_t           res
);

  localparam int NW   = 33 + FRAC;
  localparam int CNTW = $clog2(NW + 1);

  logic            running;
  logic            done;
  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   nq;
  logic [32:0]     rem;
  logic [32:0]     dmag;
  logic            neg;

  logic [32:0] nmag;
  logic [33:0] rem_sh;
  logic        ge;
  logic        over;
  logic [31:0] qlow;

  assign nmag   = numer[32] ? 33'(-numer) : 33'(numer);
  assign rem_sh = {rem, nq[NW-1]};
  assign ge     = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNTW'(NW);
        nq      <= {nmag, {FRAC{1'b0}}};
        rem     <= '0;
        dmag    <= denom[32] ? 33'(-denom) : 33'(denom);
        neg     <= numer[32] ^ denom[32];
      end else if (running) begin
        rem <= ge ? 33'(rem_sh - {1'b0, dmag}) : rem_sh[32:0];
        nq  <= {nq[NW-2:0], ge};
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign over = neg ? ((|nq[NW-1:32]) | (nq[31] & (|nq[30:0]))) : (|nq[NW-1:31]);
  assign qlow = neg ? 32'(-nq[31:0]) : nq[31:0];

  assign res.done     = done;
  assign res.sat      = over;
  assign res.quotient = over ? (neg ? WORD_MIN : WORD_MAX) : signed'(qlow);

endmodule

// File: tb/sv/newton_divided_difference_interp_unit_tb.sv
// ----------------------------------------------------------------------------
// newton_divided_difference_interp_unit_tb
// Drives clear/add/evaluate items and unused operation codes with random gaps
// and output stalls, predicts each result with a behavioral Newton-form
// interpolator and checks every transfer on the result channel in order.
// ----------------------------------------------------------------------------
module newton_divided_difference_interp_unit_tb;
  import ndi_pkg::*;

  localparam int MAXP = 16;
  localparam int FB   = 16;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit                 hold;
  } item_t;

  typedef struct {
    logic signed [31:0]   value;
    logic [STATUS_W-1:0]  st;
  } interp_res_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] operation = '0;
  logic signed [31:0] x_value = '0;
  logic signed [31:0] y_value = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] result_value;
  logic [STATUS_W-1:0] status;

  item_t       pending[$];
  interp_res_t expected_results[$];
  int  errors = 0;
  bit  stim_done = 0;
  longint cycles = 0;

  logic signed [31:0] mdl_x[MAXP];
  logic signed [31:0] mdl_row[MAXP];
  logic signed [31:0] mdl_coef[MAXP];
  int mdl_n = 0;

  newton_divided_difference_interp_unit #(.MAX_POINTS(MAXP), .FRACTION_BITS(FB)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .x_value(x_value), .y_value(y_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value), .status(status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] sat32(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1;
      return WORD_MAX;
    end
    if (v < -64'sd2147483648) begin
      flag = 1;
      return WORD_MIN;
    end
    return v[31:0];
  endfunction

  function automatic interp_res_t interp_predict(item_t it);
    interp_res_t r;
    bit sat;
    longint num, den, q, sum, d, m;
    longint unsigned ma, mb, mp;
    bit neg;
    sat = 0;
    r.value = '0;
    r.st = ST_OK;
    if (it.op == OP_CLEAR) begin
      mdl_n = 0;
    end else if (it.op == OP_ADD) begin
      if (mdl_n >= MAXP) begin
        r.st = ST_FULL;
        return r;
      end
      for (int k = 0; k < mdl_n; k++)
        if (mdl_x[k] == it.x) begin
          r.st = ST_DUPLICATE;
          return r;
        end
      mdl_x[mdl_n] = it.x;
      mdl_row[mdl_n] = it.y;
      for (int j = mdl_n - 1; j >= 0; j--) begin
        num = longint'(mdl_row[j+1]) - longint'(mdl_row[j]);
        den = longint'(it.x) - longint'(mdl_x[j]);
        q = (num * (64'sd1 << FB)) / den;
        mdl_row[j] = sat32(q, sat);
      end
      mdl_coef[mdl_n] = mdl_row[0];
      mdl_n++;
      if (sat) r.st = ST_SATURATED;
    end else if (it.op == OP_EVAL) begin
      if (mdl_n == 0) begin
        r.st = ST_EMPTY;
        return r;
      end
      sum = mdl_coef[mdl_n-1];
      for (int i = mdl_n - 2; i >= 0; i--) begin
        d = longint'(it.x) - longint'(mdl_x[i]);
        neg = (sum < 0) != (d < 0);
        ma = sum < 0 ? -sum : sum;
        mb = d < 0 ? -d : d;
        mp = (ma * mb) >> FB;
        m = neg ? -longint'(mp) : longint'(mp);
        sum = sat32(m + longint'(mdl_coef[i]), sat);
      end
      r.value = sum[31:0];
      if (sat) r.st = ST_SATURATED;
    end
    return r;
  endfunction

  task automatic push(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
                      bit hold = 0);
    item_t it;
    it.op = op;
    it.x = x;
    it.y = y;
    it.hold = hold;
    pending.push_back(it);
  endtask

  function automatic logic signed [31:0] small_val();
    return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
  endfunction

  function automatic logic signed [31:0] any_val();
    case ($urandom_range(0, 3))
      0: return WORD_MAX;
      1: return WORD_MIN;
      default: return $urandom;
    endcase
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(interp_predict(pending.pop_front()));
        in_valid <= 0;
        gap <= $urandom_range(0, 13);
        if (pending.size() == 0) stim_done <= 1;
      end else if (!in_valid) begin
        if (gap > 0) begin
          gap <= gap - 1;
        end else if (pending.size() > 0) begin
          if (!(pending[0].hold && expected_results.size() > 0)) begin
            in_valid <= 1;
            operation <= pending[0].op;
            x_value <= pending[0].x;
            y_value <= pending[0].y;
          end
        end
      end
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk) begin
    interp_res_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result value=%0d status=%0d", result_value, status);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (result_value !== e.value) begin
            $error("result_value expected %0d actual %0d", e.value, result_value);
            errors++;
          end
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            errors++;
          end
        end
        out_ready <= 0;
        stall <= $urandom_range(0, 13);
      end else if (stall > 0) begin
        stall <= stall - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  initial begin
    int n;
    push(OP_EVAL, 0, 0);
    push(OP_UNUSED, 32'sh1234, 32'sh5678);
    push(OP_ADD, 32'sh0001_0000, 32'sh0002_0000);
    push(OP_ADD, 32'sh0001_0000, 32'sh0009_0000);
    push(OP_ADD, 32'sh0002_0000, 32'sh0005_0000);
    push(OP_ADD, WORD_MIN, WORD_MAX);
    push(OP_EVAL, 32'sh0001_8000, 0);
    push(OP_EVAL, WORD_MAX, 0);
    push(OP_EVAL, WORD_MIN, 0);
    push(OP_CLEAR, 0, 0);
    push(OP_EVAL, 0, 0);
    push(OP_ADD, WORD_MAX, WORD_MIN);
    push(OP_ADD, 32'sh7FFF_FFFE, WORD_MAX);
    push(OP_EVAL, -1, -1);
    push(OP_CLEAR, -1, -1, 1);
    for (int i = 0; i < MAXP; i++) push(OP_ADD, i * 32'sh0000_8000 - 32'sh0003_0000, small_val());
    push(OP_ADD, 32'sh0100_0000, 0);
    push(OP_EVAL, 32'sh0000_4000, 0);
    while (pending.size() < 540) begin
      push(OP_CLEAR, $urandom, $urandom);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, MAXP + 2) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: push(OP_ADD, any_val(), any_val());
          1: push(OP_ADD, i == 0 ? 0 : i * 32'sh0001_0000 - 32'sh0001_0000, small_val());
          2: push(OP_EVAL, any_val(), $urandom);
          3: push($urandom_range(0, 3), $urandom, $urandom);
          default: push(OP_ADD, small_val(), small_val());
        endcase
      end
      for (int i = $urandom_range(1, 3); i > 0; i--) push(OP_EVAL, small_val(), $urandom);
    end
    repeat (8) @(posedge clk);
    rst <= 0;
  end

  initial begin
    wait (cycles > 8);
    while (!(stim_done && expected_results.size() == 0) && cycles < CYCLE_LIMIT)
      @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    repeat (2000) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
